// ===== rtl/core/rf2f32_pkg.sv =====
// ----------------------------------------------------------------------------
// Reduced float to FP32 package
// Format codes and result constants shared by the converter modules.
// ----------------------------------------------------------------------------
package rf2f32_pkg;

  typedef enum logic [1:0] {
    FMT_E4M3 = 2'd0,
    FMT_E5M2 = 2'd1,
    FMT_FP16 = 2'd2,
    FMT_BF16 = 2'd3
  } fmt_e;

  localparam logic [30:0] QNAN_MAG = 31'h7FC00000;
  localparam logic [30:0] INF_MAG  = 31'h7F800000;

endpackage

// ===== rtl/core/rf2f32_decode.sv =====
// ----------------------------------------------------------------------------
// Reduced float decoder
// Combinational conversion of one raw word to a binary32 bit pattern.
// ----------------------------------------------------------------------------
module rf2f32_decode (
  input  logic [15:0]       raw_i,
  input  rf2f32_pkg::fmt_e  fmt_i,
  output logic [31:0]       single_o
);

  logic       sign;
  logic [7:0] e;
  logic [9:0] m;
  logic [3:0] mb;
  logic [7:0] bias;
  logic       e_ones;
  logic       m_ones;
  logic [3:0] p;
  logic [9:0] frac_n;
  logic signed [9:0] biased;

  // Field extraction per format.
  always_comb begin
    sign = 1'b0; e = '0; m = '0; mb = 4'd0; bias = 8'd0; e_ones = 1'b0; m_ones = 1'b0;
    unique case (fmt_i)
      rf2f32_pkg::FMT_E4M3: begin
        sign = raw_i[7]; e = {4'd0, raw_i[6:3]}; m = {7'd0, raw_i[2:0]};
        mb = 4'd3; bias = 8'd7; e_ones = &raw_i[6:3]; m_ones = &raw_i[2:0];
      end
      rf2f32_pkg::FMT_E5M2: begin
        sign = raw_i[7]; e = {3'd0, raw_i[6:2]}; m = {8'd0, raw_i[1:0]};
        mb = 4'd2; bias = 8'd15; e_ones = &raw_i[6:2]; m_ones = &raw_i[1:0];
      end
      rf2f32_pkg::FMT_FP16: begin
        sign = raw_i[15]; e = {3'd0, raw_i[14:10]}; m = raw_i[9:0];
        mb = 4'd10; bias = 8'd15; e_ones = &raw_i[14:10]; m_ones = &raw_i[9:0];
      end
      default: begin
        sign = raw_i[15]; e = raw_i[14:7]; m = {3'd0, raw_i[6:0]};
        mb = 4'd7; bias = 8'd127; e_ones = &raw_i[14:7]; m_ones = &raw_i[6:0];
      end
    endcase
  end

  // Leading one position of the mantissa, for subnormal normalization.
  always_comb begin
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
  end

  // Assemble the binary32 word.
  always_comb begin
    frac_n = m & ~(10'd1 << p);
    biased = 10'sd0;
    single_o = {sign, 31'd0};
    if (fmt_i == rf2f32_pkg::FMT_E4M3 && e_ones && m_ones) begin
      single_o = {sign, rf2f32_pkg::QNAN_MAG};
    end else if (fmt_i != rf2f32_pkg::FMT_E4M3 && e_ones) begin
      single_o = {sign, (m != '0) ? rf2f32_pkg::QNAN_MAG : rf2f32_pkg::INF_MAG};
    end else if (e == '0) begin
      if (m != '0) begin
        if (fmt_i == rf2f32_pkg::FMT_BF16) begin
          // BF16 subnormals stay subnormal in binary32.
          single_o = {sign, 8'd0, m[6:0], 16'd0};
        end else begin
          biased = 10'sd128 + $signed({6'd0, p}) - $signed({2'd0, bias})
                   - $signed({6'd0, mb});
          single_o = {sign, biased[7:0], 23'({frac_n, 23'd0} >> p)};
        end
      end
    end else begin
      biased = $signed({2'd0, e}) - $signed({2'd0, bias}) + 10'sd127;
      single_o = {sign, biased[7:0], 23'({13'd0, m} << (5'd23 - 5'(mb)))};
    end
  end

endmodule

// ===== rtl/core/reduced_float_to_fp32.sv =====
// ----------------------------------------------------------------------------
// Reduced float to FP32 converter
// Converts FP8 E4M3, FP8 E5M2, FP16 or BF16 words to binary32.
// ----------------------------------------------------------------------------
// One transaction a cycle: the raw word is registered at start, decoded by a
// single level of combinational logic and the result is registered; done_o
// follows start through vin_q and vout_q, alongside raw_q and single_q. busy
// is always low and the receiver cannot stall; results are valid only while
// done_o is high.
module reduced_float_to_fp32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic [15:0] raw_bits_i,
  output logic        done_o,
  output logic [31:0] single_bits_o
);

  rf2f32_pkg::fmt_e fmt_q;
  logic [15:0] raw_q;
  logic        vin_q, vout_q;
  logic [31:0] single_d, single_q;

  assign busy = 1'b0;

  // Format register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmt_q <= rf2f32_pkg::FMT_E4M3;
    else if (cfg_we_i) fmt_q <= rf2f32_pkg::fmt_e'(cfg_wdata_i);
  end

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q  <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      vin_q  <= start;
      vout_q <= vin_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start) raw_q <= raw_bits_i;
    if (vin_q) single_q <= single_d;
  end

  rf2f32_decode u_dec (
    .raw_i    (raw_q),
    .fmt_i    (fmt_q),
    .single_o (single_d)
  );

  assign done_o        = vout_q;
  assign single_bits_o = single_q;

  // Each accepted transaction yields a result on done_o through vin_q and vout_q.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> ##1 done_o)
    else $error("missing result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(start, 2))
    else $error("spurious result");

endmodule
